>>> src/cnag_pkg.sv
package cnag_pkg;

  // width of dimension fields as they are used
  localparam int unsigned DIM_BITS = 16;
  localparam int unsigned DW = (DIM_BITS < 16) ? DIM_BITS : 16;
  // width of the mixed-radix dividends
  localparam int unsigned QW = 32;
  // signed width of an input row or column
  localparam int unsigned RW = DW + 10;
  localparam int unsigned GW = 16;
  localparam int unsigned OW = 64;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CFG_AW = 4;

  typedef enum logic [CFG_AW-1:0] {
    REG_INPUT_DIMS    = 4'd0,
    REG_OUTPUT_DIMS   = 4'd1,
    REG_STRIDE_PAIR   = 4'd2,
    REG_DILATION_PAIR = 4'd3,
    REG_PAD_PAIR      = 4'd4,
    REG_FILTER_DIMS   = 4'd5,
    REG_BATCH_GROUPS  = 4'd6,
    REG_CHANNEL_SIZE  = 4'd7
  } cfg_idx_e;

  // digits gathered while the item walks through the dividers
  typedef struct packed {
    logic [DW-1:0] owo;
    logic [DW-1:0] oho;
    logic [DW-1:0] ch;
    logic [DW-1:0] kx;
    logic [GW-1:0] g;
  } side_t;

  typedef struct packed {
    logic [QW-1:0] num;
    logic [DW-1:0] rem;
  } dstep_t;

  // one restoring division step: shift in the next dividend bit
  function automatic dstep_t div_step(logic [QW-1:0] num, logic [DW-1:0] rem,
                                      logic [DW-1:0] den);
    logic [DW:0] trial;
    logic        qbit;
    dstep_t      res;
    trial = {rem, num[QW-1]};
    qbit  = (trial >= {1'b0, den});
    if (qbit) begin
      trial = trial - {1'b0, den};
    end
    res.num = {num[QW-2:0], qbit};
    res.rem = trial[DW-1:0];
    return res;
  endfunction

endpackage

>>> src/cnag_div2.sv
module cnag_div2 (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [cnag_pkg::QW-1:0] a_num_i,
  input  logic [cnag_pkg::DW-1:0] a_den_i,
  input  logic [cnag_pkg::QW-1:0] b_num_i,
  input  logic [cnag_pkg::DW-1:0] b_den_i,
  input  cnag_pkg::side_t       side_i,
  output logic                  valid_o,
  output logic [cnag_pkg::QW-1:0] a_quo_o,
  output logic [cnag_pkg::DW-1:0] a_rem_o,
  output logic [cnag_pkg::QW-1:0] b_quo_o,
  output logic [cnag_pkg::DW-1:0] b_rem_o,
  output cnag_pkg::side_t       side_o
);
  import cnag_pkg::*;

  logic [QW-1:0] v_q, v_d;
  logic [QW-1:0] an_q [QW];
  logic [QW-1:0] an_d [QW];
  logic [DW-1:0] ar_q [QW];
  logic [DW-1:0] ar_d [QW];
  logic [QW-1:0] bn_q [QW];
  logic [QW-1:0] bn_d [QW];
  logic [DW-1:0] br_q [QW];
  logic [DW-1:0] br_d [QW];
  side_t         sd_q [QW];
  side_t         sd_d [QW];

  // one quotient bit per stage on both lanes
  always_comb begin
    dstep_t sa;
    dstep_t sb;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        sa       = div_step(a_num_i, '0, a_den_i);
        sb       = div_step(b_num_i, '0, b_den_i);
        v_d[s]   = valid_i;
        sd_d[s]  = side_i;
      end else begin
        sa       = div_step(an_q[s-1], ar_q[s-1], a_den_i);
        sb       = div_step(bn_q[s-1], br_q[s-1], b_den_i);
        v_d[s]   = v_q[s-1];
        sd_d[s]  = sd_q[s-1];
      end
      an_d[s] = sa.num;
      ar_d[s] = sa.rem;
      bn_d[s] = sb.num;
      br_d[s] = sb.rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        an_q[s] <= an_d[s];
        ar_q[s] <= ar_d[s];
        bn_q[s] <= bn_d[s];
        br_q[s] <= br_d[s];
        sd_q[s] <= sd_d[s];
      end
    end
  end

  // a zero radix gives digit 0 and quotient 0
  assign valid_o = v_q[QW-1];
  assign side_o  = sd_q[QW-1];
  assign a_quo_o = (a_den_i == '0) ? '0 : an_q[QW-1];
  assign a_rem_o = (a_den_i == '0) ? '0 : ar_q[QW-1];
  assign b_quo_o = (b_den_i == '0) ? '0 : bn_q[QW-1];
  assign b_rem_o = (b_den_i == '0) ? '0 : br_q[QW-1];

endmodule

>>> src/conv_nhwc_input_address_gen_core.sv
// NHWC implicit-GEMM input address generator. Takes one item (GEMM-M index,
// GEMM-K index, group) per clock unless the output stalls and returns one byte
// offset with an in-range flag per item, in order: three chained 32-stage
// restoring divider pipelines split the indices into digits (one quotient bit
// per stage); seven more stages do products, row, column, range check, four
// multiply-adds and a size shift. A stalled output freezes all stages, so
// in_ready_o follows the output register. Users must write configuration via
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while no item is in flight; unchecked.
module conv_nhwc_input_address_gen_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cnag_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [cnag_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [31:0]                 gemm_m_index_i,
  input  logic [31:0]                 gemm_k_index_i,
  input  logic [15:0]                 group_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [63:0]                 byte_offset_o,
  output logic                        in_range_o
);
  import cnag_pkg::*;

  localparam int unsigned NP = 7;

  typedef struct packed {
    logic [DW-1:0]        bn;
    logic [DW-1:0]        oho;
    logic [DW-1:0]        owo;
    logic [DW-1:0]        ky;
    logic [DW-1:0]        kx;
    logic [DW-1:0]        ch;
    logic [GW-1:0]        g;
    logic [DW+7:0]        pr1;
    logic [DW+7:0]        pr2;
    logic [DW+7:0]        pc1;
    logic [DW+7:0]        pc2;
    logic signed [RW-1:0] row;
    logic signed [RW-1:0] col;
    logic [OW-1:0]        acc;
    logic                 ok;
  } addr_t;

  // configuration registers
  logic [31:0] in_dims_q, out_dims_q, bg_q;
  logic [15:0] stride_q, dil_q, pad_q, filt_q;
  logic [17:0] chs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_dims_q  <= 32'h0001_0001;
      out_dims_q <= 32'h0001_0001;
      stride_q   <= 16'h0101;
      dil_q      <= 16'h0101;
      pad_q      <= 16'h0000;
      filt_q     <= 16'h0101;
      bg_q       <= 32'h0001_0001;
      chs_q      <= 18'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INPUT_DIMS:    in_dims_q  <= cfg_wdata_i;
        REG_OUTPUT_DIMS:   out_dims_q <= cfg_wdata_i;
        REG_STRIDE_PAIR:   stride_q   <= cfg_wdata_i[15:0];
        REG_DILATION_PAIR: dil_q      <= cfg_wdata_i[15:0];
        REG_PAD_PAIR:      pad_q      <= cfg_wdata_i[15:0];
        REG_FILTER_DIMS:   filt_q     <= cfg_wdata_i[15:0];
        REG_BATCH_GROUPS:  bg_q       <= cfg_wdata_i;
        REG_CHANNEL_SIZE:  chs_q      <= cfg_wdata_i[17:0];
        default: ;
      endcase
    end
  end

  // field extraction
  logic [DW-1:0] hi, wi, ho, wo, nb, ng, cpg, fx_w, fy_w;
  logic [7:0]    sv, sh, dv, dh, pt, pl;
  logic [1:0]    code;

  always_comb begin
    hi   = in_dims_q[16 +: DW];
    wi   = in_dims_q[0 +: DW];
    ho   = out_dims_q[16 +: DW];
    wo   = out_dims_q[0 +: DW];
    nb   = bg_q[16 +: DW];
    ng   = bg_q[0 +: DW];
    cpg  = chs_q[2 +: DW];
    code = chs_q[1:0];
    sv   = stride_q[15:8];
    sh   = stride_q[7:0];
    dv   = dil_q[15:8];
    dh   = dil_q[7:0];
    pt   = pad_q[15:8];
    pl   = pad_q[7:0];
    fx_w = DW'(filt_q[7:0]);
    fy_w = DW'(filt_q[15:8]);
  end

  // whole pipeline advances unless the output item is stalled
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // digit splitting
  logic          v1, v2, v3;
  logic [QW-1:0] mq1, kq1, mq2, kq2, mq3, kq3;
  logic [DW-1:0] owo1, ch1, oho2, kx2, bn3, ky3;
  side_t         s0, s1, s1n, s2, s2n, s3;

  assign s0 = '{owo: '0, oho: '0, ch: '0, kx: '0, g: group_index_i};

  cnag_div2 u_div_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .a_num_i(gemm_m_index_i), .a_den_i(wo),
    .b_num_i(gemm_k_index_i), .b_den_i(cpg),
    .side_i(s0), .valid_o(v1),
    .a_quo_o(mq1), .a_rem_o(owo1), .b_quo_o(kq1), .b_rem_o(ch1),
    .side_o(s1)
  );

  always_comb begin
    s1n     = s1;
    s1n.owo = owo1;
    s1n.ch  = ch1;
  end

  cnag_div2 u_div_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .a_num_i(mq1), .a_den_i(ho),
    .b_num_i(kq1), .b_den_i(fx_w),
    .side_i(s1n), .valid_o(v2),
    .a_quo_o(mq2), .a_rem_o(oho2), .b_quo_o(kq2), .b_rem_o(kx2),
    .side_o(s2)
  );

  always_comb begin
    s2n     = s2;
    s2n.oho = oho2;
    s2n.kx  = kx2;
  end

  cnag_div2 u_div_c (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .a_num_i(mq2), .a_den_i(nb),
    .b_num_i(kq2), .b_den_i(fy_w),
    .side_i(s2n), .valid_o(v3),
    .a_quo_o(mq3), .a_rem_o(bn3), .b_quo_o(kq3), .b_rem_o(ky3),
    .side_o(s3)
  );

  // address stages
  logic [NP-1:0] pv_q, pv_d;
  addr_t         p_q [NP];
  addr_t         p_d [NP];

  always_comb begin
    // products of digits with stride and dilation
    p_d[0]     = '0;
    p_d[0].bn  = bn3;
    p_d[0].ky  = ky3;
    p_d[0].oho = s3.oho;
    p_d[0].owo = s3.owo;
    p_d[0].kx  = s3.kx;
    p_d[0].ch  = s3.ch;
    p_d[0].g   = s3.g;
    p_d[0].pr1 = (DW+8)'(s3.oho) * (DW+8)'(sv);
    p_d[0].pr2 = (DW+8)'(ky3) * (DW+8)'(dv);
    p_d[0].pc1 = (DW+8)'(s3.owo) * (DW+8)'(sh);
    p_d[0].pc2 = (DW+8)'(s3.kx) * (DW+8)'(dh);
    pv_d[0]    = v3 && (mq3 == mq3) && (kq3 == kq3);

    // input row and column
    p_d[1]     = p_q[0];
    p_d[1].row = signed'(RW'(p_q[0].pr1) + RW'(p_q[0].pr2) - RW'(pt));
    p_d[1].col = signed'(RW'(p_q[0].pc1) + RW'(p_q[0].pc2) - RW'(pl));
    pv_d[1]    = pv_q[0];

    // range check and first multiply-add
    p_d[2]     = p_q[1];
    p_d[2].ok  = (p_q[1].bn < nb)
              && !p_q[1].row[RW-1] && (p_q[1].row[RW-2:0] < (RW-1)'(hi))
              && !p_q[1].col[RW-1] && (p_q[1].col[RW-2:0] < (RW-1)'(wi))
              && ((DW > GW ? DW : GW)'(p_q[1].g) < (DW > GW ? DW : GW)'(ng))
              && (p_q[1].ch < cpg);
    p_d[2].acc = OW'(p_q[1].bn) * OW'(hi) + OW'(p_q[1].row);
    pv_d[2]    = pv_q[1];

    p_d[3]     = p_q[2];
    p_d[3].acc = OW'(p_q[2].acc * OW'(wi)) + OW'(p_q[2].col);
    pv_d[3]    = pv_q[2];

    p_d[4]     = p_q[3];
    p_d[4].acc = OW'(p_q[3].acc * OW'(ng)) + OW'(p_q[3].g);
    pv_d[4]    = pv_q[3];

    p_d[5]     = p_q[4];
    p_d[5].acc = OW'(p_q[4].acc * OW'(cpg)) + OW'(p_q[4].ch);
    pv_d[5]    = pv_q[4];

    // element size scaling
    p_d[6]     = p_q[5];
    p_d[6].acc = p_q[5].acc << code;
    pv_d[6]    = pv_q[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NP; s++) begin
        p_q[s] <= p_d[s];
      end
    end
  end

  assign out_valid_o   = pv_q[NP-1];
  assign byte_offset_o = p_q[NP-1].acc;
  assign in_range_o    = p_q[NP-1].ok;

endmodule

>>> tb/sv/conv_nhwc_input_address_gen_core_tb.sv
module conv_nhwc_input_address_gen_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cnag_pkg::*;

  typedef struct {
    logic [31:0] m_idx;
    logic [31:0] k_idx;
    logic [15:0] grp;
  } access_t;

  typedef struct {
    logic [63:0] offset;
    logic        ok;
  } addr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] gemm_m_index_i = '0;
  logic [31:0] gemm_k_index_i = '0;
  logic [15:0] group_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [63:0] byte_offset_o;
  logic in_range_o;

  conv_nhwc_input_address_gen_core dut (.*);

  always #6 clk_i = ~clk_i;

  // shadow copies of the config registers
  logic [31:0] sh_in_dims, sh_out_dims, sh_bg;
  logic [15:0] sh_stride, sh_dil, sh_pad, sh_filt;
  logic [17:0] sh_chs;

  access_t     pending_q[$];
  addr_t       expected_q[$];
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_oob = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // split one index digit; zero radix gives digit 0 and kills the quotient
  function automatic logic [63:0] next_digit(ref logic [63:0] q, input logic [63:0] radix);
    logic [63:0] d;
    if (radix == 0) begin
      q = '0;
      return '0;
    end
    d = q % radix;
    q = q / radix;
    return d;
  endfunction

  function automatic addr_t nhwc_address(access_t a);
    logic [63:0] hi, wi, ho, wo, nb, ng, cpg;
    logic [63:0] m, k, owo, oho, bn, ch, kx, ky, row, col, off, grp;
    addr_t r;
    hi = 64'(sh_in_dims[31:16]);  wi = 64'(sh_in_dims[15:0]);
    ho = 64'(sh_out_dims[31:16]); wo = 64'(sh_out_dims[15:0]);
    nb = 64'(sh_bg[31:16]);       ng = 64'(sh_bg[15:0]);
    cpg = 64'(sh_chs[17:2]);
    m = 64'(a.m_idx); k = 64'(a.k_idx); grp = 64'(a.grp);
    owo = next_digit(m, wo);
    oho = next_digit(m, ho);
    bn  = next_digit(m, nb);
    ch  = next_digit(k, cpg);
    kx  = next_digit(k, 64'(sh_filt[7:0]));
    ky  = next_digit(k, 64'(sh_filt[15:8]));
    row = oho * 64'(sh_stride[15:8]) + ky * 64'(sh_dil[15:8]) - 64'(sh_pad[15:8]);
    col = owo * 64'(sh_stride[7:0]) + kx * 64'(sh_dil[7:0]) - 64'(sh_pad[7:0]);
    r.ok = bn < nb && !row[63] && row < hi && !col[63] && col < wi
           && grp < ng && ch < cpg;
    off = ((((bn * hi + row) * wi + col) * ng + grp) * cpg + ch);
    r.offset = off << sh_chs[1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // driver: hold valid until accepted, then next item or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          access_t a;
          a = pending_q.pop_front();
          expected_q = {expected_q, nhwc_address(a)};
          in_valid_i <= 1'b1;
          gemm_m_index_i <= a.m_idx;
          gemm_k_index_i <= a.k_idx;
          group_index_i <= a.grp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", byte_offset_o, '0);
      end else begin
        addr_t e;
        e = expected_q.pop_front();
        if (byte_offset_o !== e.offset) report_mismatch("byte_offset", byte_offset_o, e.offset);
        if (in_range_o !== e.ok) report_mismatch("in_range", 64'(in_range_o), 64'(e.ok));
        if (!e.ok) n_oob++;
        n_checked++;
      end
    end
  end

  task automatic write_cfg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_INPUT_DIMS:    sh_in_dims = val;
      REG_OUTPUT_DIMS:   sh_out_dims = val;
      REG_STRIDE_PAIR:   sh_stride = val[15:0];
      REG_DILATION_PAIR: sh_dil = val[15:0];
      REG_PAD_PAIR:      sh_pad = val[15:0];
      REG_FILTER_DIMS:   sh_filt = val[15:0];
      REG_BATCH_GROUPS:  sh_bg = val;
      default:           sh_chs = val[17:0];
    endcase
  endtask

  task automatic program_all(logic [31:0] ind, logic [31:0] outd, logic [15:0] str,
                             logic [15:0] dil, logic [15:0] pad, logic [15:0] filt,
                             logic [31:0] bg, logic [17:0] chs);
    write_cfg(REG_INPUT_DIMS, ind);
    write_cfg(REG_OUTPUT_DIMS, outd);
    write_cfg(REG_STRIDE_PAIR, {16'h0, str});
    write_cfg(REG_DILATION_PAIR, {16'h0, dil});
    write_cfg(REG_PAD_PAIR, {16'h0, pad});
    write_cfg(REG_FILTER_DIMS, {16'h0, filt});
    write_cfg(REG_BATCH_GROUPS, bg);
    write_cfg(REG_CHANNEL_SIZE, {14'h0, chs});
  endtask

  task automatic add_access(logic [31:0] m, logic [31:0] k, logic [15:0] g);
    access_t a;
    a.m_idx = m; a.k_idx = k; a.grp = g;
    pending_q = {pending_q, a};
  endtask

  // mostly indices inside the configured problem, some full-range noise
  task automatic add_random(int n, int unsigned m_span, int unsigned k_span,
                            int unsigned g_span);
    repeat (n) begin
      if ($urandom_range(9) < 8)
        add_access($urandom_range(m_span), $urandom_range(k_span),
                   16'($urandom_range(g_span)));
      else
        add_access($urandom, $urandom, 16'($urandom_range(16'hffff)));
    end
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  initial begin
    sh_in_dims = 32'h0001_0001; sh_out_dims = 32'h0001_0001;
    sh_stride = 16'h0101; sh_dil = 16'h0101; sh_pad = 16'h0; sh_filt = 16'h0101;
    sh_bg = 32'h0001_0001; sh_chs = 18'd10;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, field extremes
    add_access(32'd0, 32'd0, 16'd0);
    add_access(32'd1, 32'd1, 16'd0);
    add_access(32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    add_access(32'haaaa_aaaa, 32'h5555_5555, 16'h5555);
    add_access(32'h5555_5555, 32'haaaa_aaaa, 16'haaaa);
    drain();

    // small conv with padding: negative rows/cols, edges, out-of-range group
    program_all(32'h0005_0006, 32'h0005_0006, 16'h0101, 16'h0101, 16'h0101,
                16'h0303, 32'h0002_0002, {16'd3, 2'd1});
    add_access(32'd0, 32'd0, 16'd0);
    add_access(32'd29, 32'd26, 16'd1);
    add_access(32'd59, 32'd80, 16'd1);
    add_access(32'd60, 32'd0, 16'd0);
    add_access(32'd7, 32'd4, 16'd2);
    add_access(32'd0, 32'd8, 16'd0);
    drain();

    // zero-sized radices and zero tensor dims, 8-byte elements
    program_all(32'h0000_0004, 32'h0003_0000, 16'h0000, 16'hffff, 16'hffff,
                16'h00ff, 32'h0000_0000, {16'd0, 2'd3});
    add_access(32'd5, 32'd7, 16'd0);
    add_access(32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    drain();

    // maximum config values
    program_all(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff,
                16'hffff, 32'hffff_ffff, 18'h3ffff);
    add_access(32'hffff_ffff, 32'hffff_ffff, 16'hfffe);
    add_access(32'h1234_5678, 32'h9abc_def0, 16'h0);
    drain();

    // random phases with several idle patterns
    program_all(32'h0007_0009, 32'h0004_0005, 16'h0202, 16'h0101, 16'h0102,
                16'h0303, 32'h0003_0002, {16'd4, 2'd2});
    add_random(125, 3 * 4 * 5 + 6, 4 * 9 + 3, 2);
    drain();
    send_idle_pct = 75;
    program_all(32'h000c_000a, 32'h0006_0007, 16'h0201, 16'h0203, 16'h0304,
                16'h0502, 32'h0002_0003, {16'd5, 2'd0});
    add_random(125, 2 * 6 * 7 + 5, 5 * 2 * 5 + 4, 3);
    drain();
    send_idle_pct = 0; recv_stall_pct = 75;
    program_all({16'($urandom_range(1, 40)), 16'($urandom_range(1, 40))},
                {16'($urandom_range(1, 30)), 16'($urandom_range(1, 30))},
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1, 16'h0707)),
                {16'($urandom_range(1, 4)), 16'($urandom_range(1, 4))},
                {16'($urandom_range(1, 64)), 2'($urandom)});
    add_random(125, 20000, 5000, 4);
    drain();
    send_idle_pct = 8; recv_stall_pct = 8;
    program_all(32'h0020_0020, 32'h0010_0010, 16'h0202, 16'h0101, 16'h0101,
                16'h0303, 32'h0004_0001, {16'd16, 2'd1});
    add_random(125, 4 * 256 + 10, 9 * 16 + 3, 1);
    drain();

    $display("checked %0d address items (%0d out of range) over 8 config settings",
             n_checked, n_oob);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

>>> filelist.f
src/cnag_pkg.sv
src/cnag_div2.sv
src/conv_nhwc_input_address_gen_core.sv
tb/sv/conv_nhwc_input_address_gen_core_tb.sv
